FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Both macros sample on the rising edge of clk and are disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property check.
`define TDPT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define TDPT_ASSERT_IMPL(label, ante, cons, msg) \
	`TDPT_ASSERT(label, (ante) |-> (cons), msg)

`endif

FILE: design/tdpt_pkg.sv
`timescale 1ns / 1ps

package tdpt_pkg;

	// Default width of the value under test.
	localparam int NUMBER_WIDTH_DEF = 16;

	// Status that the divider reports to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

FILE: design/trial_division_prime_test_top.sv
`timescale 1ns / 1ps
// Trial-division prime test.
// Input beats arrive on s_tvalid/s_tready/s_tdata; the number sits in the low
// NUMBER_WIDTH bits of s_tdata and higher bits are ignored. Each input beat
// yields exactly one output beat on m_tvalid/m_tready/m_tdata, whose bit 0 is
// the prime flag.
// Values below two, two itself and even values finish without division: the
// sequencer goes from idle to the finish state, which loads the output
// register that drives m_tvalid once it is free. An odd value tries odd
// divisors 3, 5, 7, ... while the divisor's square does not exceed the value.
// Each divisor takes a compare in the check state and then a run of the
// shared restoring divider.
// The block handles one beat at a time: s_tready is high only while the
// sequencer is idle. The result sits in an output register, so the next beat
// may be accepted while a result waits; a further result then waits in the
// sequencer until the receiver takes the earlier one with m_tready.
// Reset (arst_n low, asynchronous) drops m_tvalid and returns to idle; no
// state is kept between items.
module trial_division_prime_test_top #(
	parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// Fields from bit 0: number[NUMBER_WIDTH-1:0], zero fill.
	input  logic [((NUMBER_WIDTH + 7) / 8) * 8-1:0] s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// Fields from bit 0: prime_flag, zero fill.
	output logic [7:0]                           m_tdata
);
	import tdpt_pkg::*;

	localparam int W    = NUMBER_WIDTH;
	localparam int SQ_W = W + 2;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CHECK  = 2'd1;
	localparam logic [1:0] ST_DIV    = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]      state_q;
	logic [W-1:0]    v_q;
	logic [W-1:0]    d_q;
	logic [SQ_W-1:0] sq_q;
	logic            res_q;
	logic            out_valid_q;
	logic            out_flag_q;
	logic [W-1:0]    v_in;
	logic            div_start;
	div_status_t     div_status;
	logic [W-1:0]    div_rem;

	assign v_in      = s_tdata[W-1:0];
	assign s_tready  = (state_q == ST_IDLE);
	assign div_start = (state_q == ST_CHECK) && (sq_q <= {2'b00, v_q});

	tdpt_divider #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (v_q),
		.divisor  (d_q),
		.status   (div_status),
		.remainder(div_rem)
	);

	// Sequencer over the candidate divisors.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (v_in[0] && (v_in > W'(2))) begin
							state_q <= ST_CHECK;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_CHECK: begin
					state_q <= div_start ? ST_DIV : ST_FINISH;
				end
				ST_DIV: begin
					if (div_status.done) begin
						state_q <= (div_rem == '0) ? ST_FINISH : ST_CHECK;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers: value, divisor, its square and the verdict.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				v_q   <= v_in;
				d_q   <= W'(3);
				sq_q  <= SQ_W'(9);
				res_q <= (v_in == W'(2));
			end
			ST_CHECK: begin
				if (!div_start) begin
					res_q <= 1'b1;
				end
			end
			ST_DIV: begin
				if (div_status.done) begin
					res_q <= 1'b0;
					d_q   <= d_q + W'(2);
					sq_q  <= sq_q + {d_q, 2'b00} + SQ_W'(4);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_flag_q  <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
				out_flag_q  <= res_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0000000, out_flag_q};

	// Checks on the sequencer and the shared divider.
	`include "assert_macros.svh"

	`TDPT_ASSERT_IMPL(a_start_idle, div_start, !div_status.busy, "divider started while busy")
	`TDPT_ASSERT_IMPL(a_done_in_div, div_status.done, state_q == ST_DIV, "stray divider done")
	`TDPT_ASSERT_IMPL(a_square_track, state_q == ST_CHECK,
		d_q[0] && (sq_q == SQ_W'({2'b00, d_q} * {2'b00, d_q})), "divisor square out of step")

endmodule

FILE: design/tdpt_divider.sv
`timescale 1ns / 1ps

// Restoring divider that produces the remainder, one quotient bit per cycle.
module tdpt_divider #(
	parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [NUMBER_WIDTH-1:0] dividend,
	input  logic [NUMBER_WIDTH-1:0] divisor,
	output tdpt_pkg::div_status_t   status,
	output logic [NUMBER_WIDTH-1:0] remainder
);
	import tdpt_pkg::*;

	localparam int W  = NUMBER_WIDTH;
	localparam int CW = $clog2(W);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          fits;

	// One shift-and-subtract step.
	always_comb begin
		trial = {rem_q, dvd_q[W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// Control: busy runs for W steps, done pulses after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
			dvd_q <= {dvd_q[W-2:0], 1'b0};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign remainder   = rem_q;

endmodule
